@@ rtl/avsc_pkg.sv @@
`default_nettype none

package avsc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_COEF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOSYNC_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_CNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_PCT    = 3'd6;

  typedef struct packed {
    logic        sync_enable;
    logic [15:0] avg_coef;
    logic [30:0] avg_threshold;
    logic [30:0] nosync_limit;
    logic [18:0] source_rate;
    logic [7:0]  warmup_count;
    logic [5:0]  correction_percent;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sync_enable:        1'b1,
    avg_coef:           16'd52057,
    avg_threshold:      31'd1311,
    nosync_limit:       31'd655360,
    source_rate:        19'd44100,
    warmup_count:       8'd20,
    correction_percent: 6'd10
  };

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [7:0]  PCT_BASE = 8'd100;

  // Division by 100 as floor(x * DIV100_K / 2^31), exact for x below 2^24.
  localparam logic [24:0] DIV100_K = 25'd21474837;

endpackage

`default_nettype wire

@@ rtl/avsc_in_if.sv @@
`default_nettype none

interface avsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] clock_diff;
  logic               diff_valid;
  logic [15:0]        frame_samples;

  modport source (output valid, output clock_diff, output diff_valid,
                  output frame_samples, input ready);
  modport sink (input valid, input clock_diff, input diff_valid,
                input frame_samples, output ready);
endinterface

`default_nettype wire

@@ rtl/avsc_out_if.sv @@
`default_nettype none

interface avsc_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] wanted_samples;
  logic        corrected;
  logic        filter_cleared;

  modport source (output valid, output wanted_samples, output corrected,
                  output filter_cleared, input ready);
  modport sink (input valid, input wanted_samples, input corrected,
                input filter_cleared, output ready);
endinterface

`default_nettype wire

@@ rtl/avsc_cfg_regs.sv @@
`default_nettype none

module avsc_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [avsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [avsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output avsc_pkg::cfg_t                         cfg
);
  import avsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_ENABLE: cfg_nxt.sync_enable        = cfg_wdata[0];
        REG_AVG_COEF:    cfg_nxt.avg_coef           = cfg_wdata[15:0];
        REG_AVG_THRESH:  cfg_nxt.avg_threshold      = cfg_wdata[30:0];
        REG_NOSYNC_LIM:  cfg_nxt.nosync_limit       = cfg_wdata[30:0];
        REG_SOURCE_RATE: cfg_nxt.source_rate        = cfg_wdata[18:0];
        REG_WARMUP_CNT:  cfg_nxt.warmup_count       = cfg_wdata[7:0];
        REG_CORR_PCT:    cfg_nxt.correction_percent = cfg_wdata[5:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/avsc_mul.sv @@
`default_nettype none

module avsc_mul (
  input  wire logic                                 clk,
  input  wire logic signed [avsc_pkg::MUL_A_W-1:0]  mul_a,
  input  wire logic signed [avsc_pkg::MUL_B_W-1:0]  mul_b,
  output logic signed [avsc_pkg::MUL_P_W-1:0]       prod
);
  import avsc_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

@@ rtl/av_sync_sample_count_corrector_unit.sv @@
// Audio/video sync sample-count corrector.
// One word on in_ch per decoded audio frame: the audio-minus-master clock
// difference, its validity flag and the frame's sample count. One word comes
// back on out_ch per input word: the wanted sample count and two flags.
// Configuration registers are to be written on the cfg_ port only while the
// block idles; the block itself does not enforce this. All multiplications
// run through one registered 33 x 26 bit multiplier under a small
// sequencer, so a word is handled one at a time. From ST_CHK the sequencer
// goes to ST_FIN directly when sync is off or the filter is cleared, via
// ACC1, ACC2 and UPD during warm-up, further via AVG0 to AVG2 and CMP below
// threshold, and further via DLT, LO1, LO2, HI1 and HI2 to a correction.
// Each 48-bit accumulator product takes two partial products, a correction
// two divisions by 100; ST_FIN waits while the output register is full.
// in_ch.ready is high while the sequencer idles, also while a result waits.
// A finished result stays in the output register until out_ch.ready takes it;
// the sequencer holds its last result until then.
// Reset clears the accumulator and measurement count and loads the default
// register values.
`default_nettype none

module av_sync_sample_count_corrector_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  avsc_in_if.sink                               in_ch,
  avsc_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [avsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [avsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import avsc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_ACC1 = 4'd2;
  localparam logic [3:0] ST_ACC2 = 4'd3;
  localparam logic [3:0] ST_UPD  = 4'd4;
  localparam logic [3:0] ST_AVG0 = 4'd5;
  localparam logic [3:0] ST_AVG1 = 4'd6;
  localparam logic [3:0] ST_AVG2 = 4'd7;
  localparam logic [3:0] ST_CMP  = 4'd8;
  localparam logic [3:0] ST_DLT  = 4'd9;
  localparam logic [3:0] ST_LO1  = 4'd10;
  localparam logic [3:0] ST_LO2  = 4'd11;
  localparam logic [3:0] ST_HI1  = 4'd12;
  localparam logic [3:0] ST_HI2  = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;

  cfg_t cfg;

  logic [3:0]                state_r, state_nxt;
  logic signed [31:0]        diff_r, diff_nxt;
  logic                      dvalid_r, dvalid_nxt;
  logic [15:0]               n_r, n_nxt;
  logic signed [47:0]        acc_r, acc_nxt;
  logic [7:0]                cnt_r, cnt_nxt;
  logic signed [63:0]        sum_r, sum_nxt;
  logic signed [34:0]        delta_r, delta_nxt;
  logic signed [35:0]        w_r, w_nxt;
  logic [16:0]               lo_r, lo_nxt;
  logic [16:0]               res_wanted_r, res_wanted_nxt;
  logic                      res_corr_r, res_corr_nxt;
  logic                      res_clr_r, res_clr_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [16:0]               out_wanted_r, out_wanted_nxt;
  logic                      out_corr_r, out_corr_nxt;
  logic                      out_clr_r, out_clr_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic [MUL_A_W-1:0]        acc_lo_a, acc_hi_a;
  logic [MUL_B_W-1:0]        coef_b, ocoef_b;
  logic [16:0]               ocoef;
  logic signed [63:0]        prod_ext;
  logic signed [63:0]        sum_add;
  logic signed [48:0]        upd_sum;
  logic signed [47:0]        upd_sat;
  logic [47:0]               avg, avg_mag;
  logic [31:0]               diff_mag;
  logic [50:0]               prod_rnd;
  logic [7:0]                pct_lo, pct_hi;
  logic [16:0]               hi_val;
  logic                      in_accept;

  avsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  avsc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign acc_lo_a = {9'd0, acc_r[23:0]};
  assign acc_hi_a = {{9{acc_r[47]}}, acc_r[47:24]};
  assign coef_b   = {10'd0, cfg.avg_coef};
  assign ocoef    = ONE_Q16 - {1'b0, cfg.avg_coef};
  assign ocoef_b  = {9'd0, ocoef};

  assign prod_ext = {{(64 - MUL_P_W){prod[MUL_P_W-1]}}, prod};
  assign sum_add  = sum_r + (prod_ext <<< 24);

  assign upd_sum  = {{17{diff_r[31]}}, diff_r} + {sum_r[63], sum_r[63:16]};
  always_comb begin
    if (upd_sum[48] != upd_sum[47]) begin
      upd_sat = upd_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      upd_sat = upd_sum[47:0];
    end
  end

  assign avg      = sum_r[63:16];
  assign avg_mag  = avg[47] ? (48'd0 - avg) : avg;
  assign diff_mag = diff_r[31] ? (32'd0 - diff_r) : diff_r;
  assign prod_rnd = prod[50:0] + (prod[50] ? 51'd65535 : 51'd0);
  assign pct_lo   = PCT_BASE - {2'd0, cfg.correction_percent};
  assign pct_hi   = PCT_BASE + {2'd0, cfg.correction_percent};
  assign hi_val   = prod[47:31];

  always_comb begin
    state_nxt      = state_r;
    diff_nxt       = diff_r;
    dvalid_nxt     = dvalid_r;
    n_nxt          = n_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    delta_nxt      = delta_r;
    w_nxt          = w_r;
    lo_nxt         = lo_r;
    res_wanted_nxt = res_wanted_r;
    res_corr_nxt   = res_corr_r;
    res_clr_nxt    = res_clr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_wanted_nxt = out_wanted_r;
    out_corr_nxt   = out_corr_r;
    out_clr_nxt    = out_clr_r;
    mul_a          = acc_lo_a;
    mul_b          = coef_b;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          diff_nxt   = in_ch.clock_diff;
          dvalid_nxt = in_ch.diff_valid;
          n_nxt      = in_ch.frame_samples;
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        res_wanted_nxt = {1'b0, n_r};
        res_corr_nxt   = 1'b0;
        res_clr_nxt    = 1'b0;
        mul_a          = acc_lo_a;
        mul_b          = coef_b;
        if (!cfg.sync_enable) begin
          state_nxt = ST_FIN;
        end else if (!dvalid_r || (diff_mag >= {1'b0, cfg.nosync_limit})) begin
          acc_nxt     = '0;
          cnt_nxt     = '0;
          res_clr_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          state_nxt = ST_ACC1;
        end
      end
      ST_ACC1: begin
        sum_nxt   = prod_ext;
        mul_a     = acc_hi_a;
        mul_b     = coef_b;
        state_nxt = ST_ACC2;
      end
      ST_ACC2: begin
        sum_nxt   = sum_add;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        acc_nxt = upd_sat;
        if (cnt_r < cfg.warmup_count) begin
          cnt_nxt   = cnt_r + 8'd1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_AVG0;
        end
      end
      ST_AVG0: begin
        mul_a     = acc_lo_a;
        mul_b     = ocoef_b;
        state_nxt = ST_AVG1;
      end
      ST_AVG1: begin
        sum_nxt   = prod_ext;
        mul_a     = acc_hi_a;
        mul_b     = ocoef_b;
        state_nxt = ST_AVG2;
      end
      ST_AVG2: begin
        sum_nxt   = sum_add;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        mul_a = {diff_r[31], diff_r};
        mul_b = {7'd0, cfg.source_rate};
        if (avg_mag >= {17'd0, cfg.avg_threshold}) begin
          state_nxt = ST_DLT;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DLT: begin
        delta_nxt = prod_rnd[50:16];
        mul_a     = {17'd0, n_r};
        mul_b     = {18'd0, pct_lo};
        state_nxt = ST_LO1;
      end
      ST_LO1: begin
        w_nxt     = {20'd0, n_r} + {delta_r[34], delta_r};
        mul_a     = {9'd0, prod[23:0]};
        mul_b     = {1'b0, DIV100_K};
        state_nxt = ST_LO2;
      end
      ST_LO2: begin
        lo_nxt    = prod[47:31];
        mul_a     = {17'd0, n_r};
        mul_b     = {18'd0, pct_hi};
        state_nxt = ST_HI1;
      end
      ST_HI1: begin
        mul_a     = {9'd0, prod[23:0]};
        mul_b     = {1'b0, DIV100_K};
        state_nxt = ST_HI2;
      end
      ST_HI2: begin
        res_corr_nxt = 1'b1;
        if (w_r < $signed({19'd0, lo_r})) begin
          res_wanted_nxt = lo_r;
        end else if (w_r > $signed({19'd0, hi_val})) begin
          res_wanted_nxt = hi_val;
        end else begin
          res_wanted_nxt = w_r[16:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_wanted_nxt = res_wanted_r;
          out_corr_nxt   = res_corr_r;
          out_clr_nxt    = res_clr_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r       <= diff_nxt;
    dvalid_r     <= dvalid_nxt;
    n_r          <= n_nxt;
    sum_r        <= sum_nxt;
    delta_r      <= delta_nxt;
    w_r          <= w_nxt;
    lo_r         <= lo_nxt;
    res_wanted_r <= res_wanted_nxt;
    res_corr_r   <= res_corr_nxt;
    res_clr_r    <= res_clr_nxt;
    out_wanted_r <= out_wanted_nxt;
    out_corr_r   <= out_corr_nxt;
    out_clr_r    <= out_clr_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.wanted_samples = out_wanted_r;
  assign out_ch.corrected      = out_corr_r;
  assign out_ch.filter_cleared = out_clr_r;

endmodule

`default_nettype wire

@@ test/av_sync_sample_count_corrector_unit_checker.sv @@
`timescale 1ns / 100ps

module av_sync_sample_count_corrector_unit_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  avsc_in_if                                   in_mon,
  avsc_out_if                                  out_mon,
  input  wire logic                            cfg_we,
  input  wire logic [avsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [avsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                   mismatches,
  output int                                   words_pending,
  output int                                   words_checked,
  output int                                   corrections_seen,
  output int                                   clears_seen
);

  typedef struct packed {
    logic [16:0] wanted_samples;
    logic        corrected;
    logic        filter_cleared;
  } frame_result_t;

  localparam longint ACCUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACCUM_MIN = -ACCUM_MAX - 1;

  avsc_pkg::cfg_t  shadow_cfg;
  longint          accum;
  logic [7:0]      meas_cnt;
  frame_result_t   wanted_q[$];
  int              err_count;
  int              checked_count;
  int              corr_count;
  int              clear_count;

  function automatic frame_result_t predict_wanted_count(input logic signed [31:0] diff_raw,
                                                         input logic dv,
                                                         input logic [15:0] n);
    longint        d;
    longint        mag;
    longint        sum;
    longint        avg;
    longint        delta;
    longint        w;
    longint        lo;
    longint        hi;
    longint        nl;
    longint        pct;
    frame_result_t r;
    d = longint'(diff_raw);
    nl = longint'(n);
    r.wanted_samples = {1'b0, n};
    r.corrected = 1'b0;
    r.filter_cleared = 1'b0;
    if (shadow_cfg.sync_enable) begin
      mag = (d < 0) ? -d : d;
      if (dv && mag < longint'(shadow_cfg.nosync_limit)) begin
        sum = d + ((longint'(shadow_cfg.avg_coef) * accum) >>> 16);
        if (sum > ACCUM_MAX) sum = ACCUM_MAX;
        if (sum < ACCUM_MIN) sum = ACCUM_MIN;
        accum = sum;
        if (meas_cnt < shadow_cfg.warmup_count) begin
          meas_cnt = meas_cnt + 8'd1;
        end else begin
          avg = (accum * (65536 - longint'(shadow_cfg.avg_coef))) >>> 16;
          if (((avg < 0) ? -avg : avg) >= longint'(shadow_cfg.avg_threshold)) begin
            delta = (d * longint'(shadow_cfg.source_rate)) / 65536;
            pct = longint'(shadow_cfg.correction_percent);
            lo = nl * (100 - pct) / 100;
            hi = nl * (100 + pct) / 100;
            w = nl + delta;
            if (w < lo) w = lo;
            if (w > hi) w = hi;
            r.wanted_samples = w[16:0];
            r.corrected = 1'b1;
          end
        end
      end else begin
        accum = 0;
        meas_cnt = 8'd0;
        r.filter_cleared = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      shadow_cfg = avsc_pkg::CFG_RESET;
      accum = 0;
      meas_cnt = 8'd0;
      wanted_q.delete();
      err_count = 0;
      checked_count = 0;
      corr_count = 0;
      clear_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          avsc_pkg::REG_SYNC_ENABLE: shadow_cfg.sync_enable = cfg_wdata[0];
          avsc_pkg::REG_AVG_COEF:    shadow_cfg.avg_coef = cfg_wdata[15:0];
          avsc_pkg::REG_AVG_THRESH:  shadow_cfg.avg_threshold = cfg_wdata[30:0];
          avsc_pkg::REG_NOSYNC_LIM:  shadow_cfg.nosync_limit = cfg_wdata[30:0];
          avsc_pkg::REG_SOURCE_RATE: shadow_cfg.source_rate = cfg_wdata[18:0];
          avsc_pkg::REG_WARMUP_CNT:  shadow_cfg.warmup_count = cfg_wdata[7:0];
          avsc_pkg::REG_CORR_PCT:    shadow_cfg.correction_percent = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (wanted_q.size() == 0) begin
          $display("%0t: result word with no word outstanding, got %0d/%b/%b", $time,
                   out_mon.wanted_samples, out_mon.corrected, out_mon.filter_cleared);
          err_count++;
        end else begin
          want = wanted_q.pop_front();
          report_field("wanted_samples", want.wanted_samples, out_mon.wanted_samples);
          report_field("corrected", 17'(want.corrected), 17'(out_mon.corrected));
          report_field("filter_cleared", 17'(want.filter_cleared), 17'(out_mon.filter_cleared));
          checked_count++;
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        want = predict_wanted_count(in_mon.clock_diff, in_mon.diff_valid, in_mon.frame_samples);
        if (want.corrected) corr_count++;
        if (want.filter_cleared) clear_count++;
        wanted_q.push_back(want);
      end
    end
    mismatches <= err_count;
    words_pending <= wanted_q.size();
    words_checked <= checked_count;
    corrections_seen <= corr_count;
    clears_seen <= clear_count;
  end

endmodule

@@ test/av_sync_sample_count_corrector_unit_test.sv @@
`timescale 1ns / 100ps

module av_sync_sample_count_corrector_unit_test;

  localparam int PHASES          = 14;
  localparam int WORDS_PER_PHASE = 138;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_AFTER      = 760;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 32;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [avsc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [avsc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int checked;
  int corrections;
  int clears;
  int words_sent = 0;
  int settings_loaded = 0;
  int gap_pct = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  avsc_in_if  in_ch();
  avsc_out_if out_ch();

  av_sync_sample_count_corrector_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  av_sync_sample_count_corrector_unit_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .words_pending    (pending),
    .words_checked    (checked),
    .corrections_seen (corrections),
    .clears_seen      (clears)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls in bursts, and once holds off long enough to back up the input.
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && words_sent >= HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic signed [31:0] diff, input logic dv,
                           input logic [15:0] n);
    if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.clock_diff <= diff;
    in_ch.diff_valid <= dv;
    in_ch.frame_samples <= n;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [avsc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [avsc_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input avsc_pkg::cfg_t c);
    put_reg(avsc_pkg::REG_SYNC_ENABLE, 31'(c.sync_enable));
    put_reg(avsc_pkg::REG_AVG_COEF,    31'(c.avg_coef));
    put_reg(avsc_pkg::REG_AVG_THRESH,  31'(c.avg_threshold));
    put_reg(avsc_pkg::REG_NOSYNC_LIM,  31'(c.nosync_limit));
    put_reg(avsc_pkg::REG_SOURCE_RATE, 31'(c.source_rate));
    put_reg(avsc_pkg::REG_WARMUP_CNT,  31'(c.warmup_count));
    put_reg(avsc_pkg::REG_CORR_PCT,    31'(c.correction_percent));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    avsc_pkg::cfg_t     s;
    longint             lim;
    longint             thr;
    longint             base;
    longint             d;
    int                 run_left;
    int                 sel;
    logic signed [31:0] diff;
    logic               dv;
    logic [15:0]        n;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= avsc_pkg::REG_SYNC_ENABLE;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.clock_diff <= '0;
    in_ch.diff_valid <= 1'b0;
    in_ch.frame_samples <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short warm-up so corrections show up within the directed words.
    s = avsc_pkg::CFG_RESET;
    s.warmup_count = 8'd2;
    load_settings(s);
    send_word(32'sd0, 1'b1, 16'd0);
    send_word(32'sh7FFFFFFF, 1'b1, 16'hFFFF);
    send_word(32'sh80000000, 1'b1, 16'hFFFF);
    send_word(32'sd1234, 1'b0, 16'd100);
    send_word(32'sd655360, 1'b1, 16'd500);
    repeat (4) send_word(32'sd6553, 1'b1, 16'd1024);
    send_word(32'sd655359, 1'b1, 16'hFFFF);
    send_word(-32'sd655359, 1'b1, 16'hFFFF);
    send_word(-32'sd6553, 1'b1, 16'd0);
    send_word(-32'sd6553, 1'b1, 16'hFFFF);
    drain();

    // With sync off the filter state must survive an invalid word.
    s.sync_enable = 1'b0;
    load_settings(s);
    send_word(32'sd6553, 1'b1, 16'd1000);
    send_word(32'sd0, 1'b0, 16'hFFFF);
    drain();

    s.sync_enable = 1'b1;
    s.source_rate = 19'd0;
    s.correction_percent = 6'd63;
    load_settings(s);
    repeat (3) send_word(32'sd6553, 1'b1, 16'd40000);
    drain();

    s.source_rate = 19'h7FFFF;
    load_settings(s);
    send_word(32'sd655359, 1'b1, 16'hFFFF);
    send_word(-32'sd655359, 1'b1, 16'hFFFF);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = avsc_pkg::CFG_RESET;
        1: begin
          s.sync_enable = 1'b1;
          s.avg_coef = 16'd0;
          s.avg_threshold = 31'd0;
          s.nosync_limit = 31'h7FFFFFFF;
          s.source_rate = 19'd384000;
          s.warmup_count = 8'd0;
          s.correction_percent = 6'd50;
        end
        2: begin
          s.sync_enable = 1'b1;
          s.avg_coef = 16'hFFFF;
          s.avg_threshold = 31'h7FFFFFFF;
          s.nosync_limit = 31'd0;
          s.source_rate = 19'd1;
          s.warmup_count = 8'hFF;
          s.correction_percent = 6'd0;
        end
        3: begin
          s.sync_enable = 1'b1;
          s.avg_coef = 16'hFFFF;
          s.avg_threshold = 31'd1311;
          s.nosync_limit = 31'h7FFFFFFF;
          s.source_rate = 19'h7FFFF;
          s.warmup_count = 8'd0;
          s.correction_percent = 6'd63;
        end
        default: begin
          s.sync_enable = ($urandom_range(0, 9) != 0);
          s.avg_coef = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(40000, 65000));
          s.avg_threshold = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                        : 31'($urandom_range(0, 20000));
          s.nosync_limit = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                       : 31'($urandom_range(65536, 1000000));
          s.source_rate = ($urandom_range(0, 5) == 0) ? 19'($urandom)
                                                      : 19'($urandom_range(8000, 384000));
          s.warmup_count = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 24));
          s.correction_percent = 6'($urandom_range(0, 63));
        end
      endcase
      quiet = (p == PHASES - 1);
      gap_pct = (p % 4 == 1) ? 0 : $urandom_range(5, 60);
      load_settings(s);
      lim = longint'(s.nosync_limit);
      thr = longint'(s.avg_threshold);
      run_left = 0;
      base = 0;
      repeat (WORDS_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        dv = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
          n = 16'($urandom);
        end
        if (sel < 75 && lim > 0) begin
          // Steady drift with jitter lets the average settle past warm-up.
          if (run_left == 0) begin
            run_left = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
              0: base = longint'($urandom) % (2 * thr + 4097);
              1: base = longint'($urandom) % lim;
              default: base = longint'($urandom_range(0, 256));
            endcase
            if ($urandom_range(0, 1) != 0) base = -base;
          end
          run_left--;
          d = base + longint'($urandom_range(0, 2048)) - 1024;
          if (d >= lim) d = lim - 1;
          if (d <= -lim) d = -(lim - 1);
          diff = d[31:0];
        end else if (sel < 85) begin
          dv = 1'b0;
          diff = $urandom;
        end else if (sel < 92) begin
          d = lim + longint'($urandom_range(0, 5000));
          if ($urandom_range(0, 1) != 0) begin
            if (d > 64'sd2147483647) d = 64'sd2147483647;
          end else begin
            d = -d;
            if (d < -64'sd2147483648) d = -64'sd2147483648;
          end
          diff = d[31:0];
        end else begin
          diff = $urandom;
          dv = 1'($urandom_range(0, 1));
        end
        send_word(diff, dv, n);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words across %0d register settings, with one long output stall.",
             words_sent, settings_loaded);
    $display("Checked %0d results: %0d corrected, %0d with the filter cleared.",
             checked, corrections, clears);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/avsc_pkg.sv
rtl/avsc_in_if.sv
rtl/avsc_out_if.sv
rtl/avsc_cfg_regs.sv
rtl/avsc_mul.sv
rtl/av_sync_sample_count_corrector_unit.sv
test/av_sync_sample_count_corrector_unit_checker.sv
test/av_sync_sample_count_corrector_unit_test.sv
